FILE: src/csq_pkg.sv
`default_nettype none
package csq_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Request codes
  localparam logic [2:0] REQ_START   = 3'd0;
  localparam logic [2:0] REQ_ADVANCE = 3'd1;
  localparam logic [2:0] REQ_INSERT  = 3'd2;
  localparam logic [2:0] REQ_ATTACH  = 3'd3;
  localparam logic [2:0] REQ_REMOVE  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NOITEM = 2'd2;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  item_count;
    logic        has_current;
    logic [31:0] current_value;
    logic [6:0]  cursor_position;
  } out_t;

  // What one cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PREV,
    CELL_NEXT
  } cell_op_t;

  // What a whole stack does in a cycle
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_LOAD
  } stk_op_t;

  typedef struct packed {
    stk_op_t op;
    data_t   data;
  } stk_ctrl_t;

endpackage
`default_nettype wire

FILE: src/csq_cell.sv
`default_nettype none
module csq_cell
  import csq_pkg::*;
(
  input  wire      clk,
  input  cell_op_t op,
  input  data_t    prev_d,
  input  data_t    next_d,
  output data_t    q
);

  data_t q_r;
  data_t q_nxt;

  // Take from the neighbor on either side, or hold
  always_comb begin
    case (op)
      CELL_PREV: q_nxt = prev_d;
      CELL_NEXT: q_nxt = next_d;
      default:   q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

FILE: src/csq_stack.sv
`default_nettype none
module csq_stack
  import csq_pkg::*;
(
  input  wire       clk,
  input  stk_ctrl_t ctrl,
  output data_t     top0,
  output data_t     top1
);

  data_t    cell_q  [CAPACITY];
  cell_op_t cell_op [CAPACITY];

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      data_t prev_d;
      data_t next_d;

      // Cell zero is the top: it sees the pushed word on its upper side
      if (i == 0) begin : g_top
        assign prev_d = ctrl.data;
      end else begin : g_mid
        assign prev_d = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign next_d = cell_q[i];
      end else begin : g_inner
        assign next_d = cell_q[i+1];
      end

      // Push shifts the chain down, pop shifts it up, load touches the top only
      always_comb begin
        case (ctrl.op)
          STK_PUSH: cell_op[i] = CELL_PREV;
          STK_POP:  cell_op[i] = CELL_NEXT;
          STK_LOAD: cell_op[i] = (i == 0) ? CELL_PREV : CELL_HOLD;
          default:  cell_op[i] = CELL_HOLD;
        endcase
      end

      csq_cell u_cell (
        .clk    (clk),
        .op     (cell_op[i]),
        .prev_d (prev_d),
        .next_d (next_d),
        .q      (cell_q[i])
      );
    end

    if (CAPACITY > 1) begin : g_two
      assign top1 = cell_q[1];
    end else begin : g_one
      assign top1 = cell_q[0];
    end
  endgenerate

  assign top0 = cell_q[0];

endmodule
`default_nettype wire

FILE: src/cursor_sequence_store.sv
// Ordered store of up to CAPACITY words with a cursor, held as two chains of
// cells: the left chain keeps the entries before the cursor (nearest on top),
// the right chain keeps the current entry on top and the entries after it.
// Advance, insert with a current entry, attach, remove and query are carried
// out in the request beat, and their result is written to the result buffer.
// Start with the cursor at position k, and insert with no current entry and
// k stored entries, go through a rewind when k is above zero: the left chain
// hands one word a cycle onto the right chain until it is empty, and a final
// step places the front word and writes the result. A two-deep result buffer
// lets a new request beat in while an earlier result still waits on out_ready.
`default_nettype none
module cursor_sequence_store
  import csq_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  wire  out_ready,
  output out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_REWIND = 2'b10
  } state_t;

  state_t    state_r, state_nxt;
  cnt_t      left_cnt_r, left_cnt_nxt;
  cnt_t      right_cnt_r, right_cnt_nxt;
  logic      ins_pend_r, ins_pend_nxt;
  data_t     word_r, word_nxt;

  stk_ctrl_t left_ctrl, right_ctrl;
  data_t     left_top0, left_top1;
  data_t     right_top0, right_top1;
  data_t     right_top_nxt;
  data_t     in_word;
  cnt_t      count;
  logic      has_cur;
  logic      full;
  logic      in_beat;

  logic      res_push;
  logic [1:0] res_status;
  out_t      res;

  out_t      e0_r, e0_nxt, e1_r, e1_nxt;
  logic      v0_r, v0_nxt, v1_r, v1_nxt;
  logic      res_pop;

  csq_stack u_left (
    .clk  (clk),
    .ctrl (left_ctrl),
    .top0 (left_top0),
    .top1 (left_top1)
  );

  csq_stack u_right (
    .clk  (clk),
    .ctrl (right_ctrl),
    .top0 (right_top0),
    .top1 (right_top1)
  );

  assign in_word = data_t'(in_data.entry_value);
  assign count   = cnt_t'(left_cnt_r + right_cnt_r);
  assign has_cur = (right_cnt_r != '0);
  assign full    = (count >= cnt_t'(CAPACITY));
  assign in_ready = (state_r == S_IDLE) && !v1_r;
  assign in_beat  = in_valid && in_ready;

  // Decode requests and drive both chains
  always_comb begin
    state_nxt       = state_r;
    left_cnt_nxt    = left_cnt_r;
    right_cnt_nxt   = right_cnt_r;
    ins_pend_nxt    = ins_pend_r;
    word_nxt        = word_r;
    left_ctrl.op    = STK_HOLD;
    left_ctrl.data  = right_top0;
    right_ctrl.op   = STK_HOLD;
    right_ctrl.data = in_word;
    res_push        = 1'b0;
    res_status      = ST_DONE;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          res_push = 1'b1;
          case (in_data.req_type)
            REQ_START: begin
              if (left_cnt_r != '0) begin
                res_push     = 1'b0;
                ins_pend_nxt = 1'b0;
                state_nxt    = S_REWIND;
              end
            end
            REQ_ADVANCE: begin
              if (has_cur) begin
                left_ctrl.op  = STK_PUSH;
                right_ctrl.op = STK_POP;
                left_cnt_nxt  = cnt_t'(left_cnt_r + 1'b1);
                right_cnt_nxt = cnt_t'(right_cnt_r - 1'b1);
              end else begin
                res_status = ST_NOITEM;
              end
            end
            REQ_INSERT: begin
              if (full) begin
                res_status = ST_FULL;
              end else if (has_cur || (left_cnt_r == '0)) begin
                right_ctrl.op = STK_PUSH;
                right_cnt_nxt = cnt_t'(right_cnt_r + 1'b1);
              end else begin
                res_push     = 1'b0;
                ins_pend_nxt = 1'b1;
                word_nxt     = in_word;
                state_nxt    = S_REWIND;
              end
            end
            REQ_ATTACH: begin
              if (full) begin
                res_status = ST_FULL;
              end else if (has_cur) begin
                left_ctrl.op  = STK_PUSH;
                right_ctrl.op = STK_LOAD;
                left_cnt_nxt  = cnt_t'(left_cnt_r + 1'b1);
              end else begin
                right_ctrl.op = STK_PUSH;
                right_cnt_nxt = cnt_t'(right_cnt_r + 1'b1);
              end
            end
            REQ_REMOVE: begin
              if (has_cur) begin
                right_ctrl.op = STK_POP;
                right_cnt_nxt = cnt_t'(right_cnt_r - 1'b1);
              end else begin
                res_status = ST_NOITEM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REWIND: begin
        if (left_cnt_r != '0) begin
          // Move one word from the left top onto the right top
          left_ctrl.op    = STK_POP;
          right_ctrl.op   = STK_PUSH;
          right_ctrl.data = left_top0;
          left_cnt_nxt    = cnt_t'(left_cnt_r - 1'b1);
          right_cnt_nxt   = cnt_t'(right_cnt_r + 1'b1);
        end else begin
          // Finish: place the held word at the front if an insert waits
          if (ins_pend_r) begin
            right_ctrl.op   = STK_PUSH;
            right_ctrl.data = word_r;
            right_cnt_nxt   = cnt_t'(right_cnt_r + 1'b1);
          end
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Work out the top of the right chain after this cycle
  always_comb begin
    case (right_ctrl.op)
      STK_PUSH, STK_LOAD: right_top_nxt = right_ctrl.data;
      STK_POP:            right_top_nxt = right_top1;
      default:            right_top_nxt = right_top0;
    endcase
  end

  // Build the result beat from the state after the request
  always_comb begin
    res.status          = res_status;
    res.item_count      = 7'(left_cnt_nxt + right_cnt_nxt);
    res.has_current     = (right_cnt_nxt != '0);
    res.current_value   = (right_cnt_nxt != '0) ? 32'(right_top_nxt) : 32'd0;
    res.cursor_position = 7'(left_cnt_nxt);
  end

  // Two-deep result buffer: advance on a taken beat, fill the first free slot
  assign res_pop = v0_r && out_ready;

  always_comb begin
    e0_nxt = res_pop ? e1_r : e0_r;
    v0_nxt = res_pop ? v1_r : v0_r;
    e1_nxt = e1_r;
    v1_nxt = res_pop ? 1'b0 : v1_r;
    if (res_push) begin
      if (!v0_nxt) begin
        e0_nxt = res;
        v0_nxt = 1'b1;
      end else begin
        e1_nxt = res;
        v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
      ins_pend_r  <= 1'b0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_cnt_r  <= left_cnt_nxt;
      right_cnt_r <= right_cnt_nxt;
      ins_pend_r  <= ins_pend_nxt;
      v0_r        <= v0_nxt;
      v1_r        <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    e0_r   <= e0_nxt;
    e1_r   <= e1_nxt;
  end

  assign out_valid = v0_r;
  assign out_data  = e0_r;

  // Second tap of the left chain is not needed for any request
  logic unused_left;
  assign unused_left = ^left_top1;

endmodule
`default_nettype wire

FILE: src/csq_check.sv
`default_nettype none
module csq_check
  import csq_pkg::*;
(
  input wire  clk,
  input wire  rst_n,
  input wire  out_valid,
  input wire  out_ready,
  input out_t out_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Keep the cursor within the stored entries
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cursor_position <= out_data.item_count)
    else $error("cursor beyond entry count");

  // Tie the current flag to the cursor position
  a_has_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.has_current ==
                  (out_data.cursor_position != out_data.item_count))
    else $error("current flag disagrees with cursor");

  // Drive zero when there is no current entry
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_current |-> out_data.current_value == 32'd0)
    else $error("value shown without a current entry");

  // Never report more entries than the store holds
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.item_count <= 7'(CAPACITY))
    else $error("entry count above capacity");

endmodule

bind cursor_sequence_store csq_check u_csq_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

FILE: bench/cursor_sequence_store_test.sv
`timescale 1ns / 1ps
module cursor_sequence_store_test;
  import csq_pkg::*;

  // Request codes beyond the ones the package names
  localparam logic [2:0] REQ_QUERY   = 3'd5;
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  // Random traffic mixes
  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_ITEMS  = 200;
  localparam int HOLD_FROM    = 600;
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int LIMIT_CYCLES = 1000000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Shadow copy of the store
  data_t model_words [CAPACITY];
  int    model_count;
  int    model_cursor;

  in_t  request_queue [$];
  out_t expected_reports [$];
  out_t wanted_report;

  int   send_gap;
  int   recv_stall;
  int   hold_count;
  int   run_cycles;
  int   mismatches;
  logic quiet_tail;
  logic hold_off;

  cursor_sequence_store dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow store and build the report it yields
  function automatic out_t apply_request(in_t req);
    out_t       rep;
    logic [1:0] st;
    int         pos;
    bit         cur;
    cur = model_cursor < model_count;
    st  = ST_DONE;
    case (req.req_type)
      REQ_START: begin
        model_cursor = 0;
      end
      REQ_ADVANCE: begin
        if (cur) model_cursor++;
        else st = ST_NOITEM;
      end
      REQ_INSERT, REQ_ATTACH: begin
        if (model_count >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          if (req.req_type == REQ_INSERT) pos = cur ? model_cursor : 0;
          else pos = cur ? model_cursor + 1 : model_count;
          for (int i = model_count; i > pos; i--) model_words[i] = model_words[i-1];
          model_words[pos] = data_t'(req.entry_value);
          model_count++;
          model_cursor = pos;
        end
      end
      REQ_REMOVE: begin
        if (cur) begin
          for (int i = model_cursor; i < model_count - 1; i++)
            model_words[i] = model_words[i+1];
          model_count--;
        end else begin
          st = ST_NOITEM;
        end
      end
      default: ;
    endcase
    cur = model_cursor < model_count;
    rep.status          = st;
    rep.item_count      = 7'(model_count);
    rep.has_current     = cur;
    rep.current_value   = cur ? 32'(model_words[model_cursor]) : 32'd0;
    rep.cursor_position = 7'(model_cursor);
    return rep;
  endfunction

  task automatic add_request(logic [2:0] kind, logic [31:0] word);
    in_t req;
    req.req_type    = kind;
    req.entry_value = word;
    request_queue.push_back(req);
  endtask

  function automatic logic [2:0] pick_kind(int mode);
    int         roll;
    logic [2:0] spare;
    roll  = $urandom_range(0, 99);
    spare = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
    case (mode)
      MODE_GROW: begin
        if (roll < 35) return REQ_INSERT;
        else if (roll < 70) return REQ_ATTACH;
        else if (roll < 80) return REQ_ADVANCE;
        else if (roll < 85) return REQ_START;
        else if (roll < 90) return REQ_REMOVE;
        else if (roll < 96) return REQ_QUERY;
        else return spare;
      end
      MODE_SHRINK: begin
        if (roll < 45) return REQ_REMOVE;
        else if (roll < 65) return REQ_ADVANCE;
        else if (roll < 75) return REQ_START;
        else if (roll < 83) return REQ_INSERT;
        else if (roll < 91) return REQ_ATTACH;
        else if (roll < 96) return REQ_QUERY;
        else return spare;
      end
      default: begin
        if (roll < 10) return REQ_START;
        else if (roll < 35) return REQ_ADVANCE;
        else if (roll < 53) return REQ_INSERT;
        else if (roll < 71) return REQ_ATTACH;
        else if (roll < 90) return REQ_REMOVE;
        else if (roll < 96) return REQ_QUERY;
        else return spare;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 32'd0;
    else if (roll == 1) return '1;
    else return $urandom();
  endfunction

  // Fill the request list, release reset, wait for the drain, report
  initial begin
    int mode;
    int run;
    int made;
    model_count  = 0;
    model_cursor = 0;
    mismatches   = 0;

    // Directed: empty store, cursor walk off the end, front insert, tail append
    add_request(REQ_START, $urandom());
    add_request(REQ_ADVANCE, $urandom());
    add_request(REQ_REMOVE, $urandom());
    add_request(REQ_QUERY, $urandom());
    add_request(REQ_INSERT, 32'hFFFF_FFFF);
    add_request(REQ_ATTACH, 32'h0000_0000);
    add_request(REQ_START, $urandom());
    add_request(REQ_INSERT, 32'hA5A5_A5A5);
    add_request(REQ_ADVANCE, $urandom());
    add_request(REQ_ADVANCE, $urandom());
    add_request(REQ_ADVANCE, $urandom());
    add_request(REQ_ATTACH, 32'h5A5A_5A5A);
    add_request(REQ_REMOVE, $urandom());
    add_request(REQ_ADVANCE, $urandom());
    add_request(REQ_INSERT, 32'h1234_5678);
    add_request(REQ_REMOVE, $urandom());
    add_request(REQ_SPARE_A, $urandom());
    add_request(REQ_SPARE_B, $urandom());
    add_request(REQ_QUERY, $urandom());
    add_request(REQ_START, $urandom());

    // Random: bursts of one traffic mix so the store swings between full and empty
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode = $urandom_range(MODE_GROW, MODE_MIXED);
      run  = $urandom_range(30, 120);
      for (int i = 0; i < run && made < RANDOM_ITEMS; i++) begin
        add_request(pick_kind(mode), pick_word());
        made++;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: offer the next request, predict on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      send_gap   <= 0;
      quiet_tail <= 1'b0;
    end else begin
      quiet_tail <= request_queue.size() <= QUIET_ITEMS;
      if (!in_valid || in_ready) begin
        if (in_valid) expected_reports.push_back(apply_request(in_data));
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          in_data  <= request_queue.pop_front();
          in_valid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result st=%0d cnt=%0d cur=%0b val=%h pos=%0d",
                     $realtime, out_data.status, out_data.item_count,
                     out_data.has_current, out_data.current_value, out_data.cursor_position);
        end else begin
          wanted_report = expected_reports.pop_front();
          if (out_data.status !== wanted_report.status ||
              out_data.item_count !== wanted_report.item_count ||
              out_data.has_current !== wanted_report.has_current ||
              out_data.current_value !== wanted_report.current_value ||
              out_data.cursor_position !== wanted_report.cursor_position) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result differs: exp st=%0d cnt=%0d cur=%0b val=%h pos=%0d",
                       $realtime,
                       wanted_report.status, wanted_report.item_count,
                       wanted_report.has_current, wanted_report.current_value,
                       wanted_report.cursor_position);
              $display("  got st=%0d cnt=%0d cur=%0b val=%h pos=%0d",
                       out_data.status, out_data.item_count, out_data.has_current,
                       out_data.current_value, out_data.cursor_position);
            end
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready  <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        recv_stall <= $urandom_range(0, 17);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hold off the receiver for a long stretch so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_count <= 0;
      hold_off   <= 1'b0;
    end else begin
      hold_count <= hold_count + 1;
      hold_off   <= hold_count >= HOLD_FROM && hold_count < HOLD_FROM + HOLD_LEN;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    run_cycles <= run_cycles + 1;
    if (run_cycles >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial run_cycles = 0;

endmodule
